FILE: rtl/core/gif_lzw_encoder_top_macros.svh
// Assertion macros for the GIF LZW encoder checker.
// Used by gle_checker.sv; no other dependencies.
`ifndef GIF_LZW_ENCODER_TOP_MACROS_SVH
`define GIF_LZW_ENCODER_TOP_MACROS_SVH

// clocked assertion with reset disable
`define GLE_ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds through reset
`define GLE_ASSERT_ALL(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/gle_pkg.sv
// Shared types, constants and helpers of the GIF LZW encoder.
// No dependencies.
`timescale 1ns / 1ps

package gle_pkg;

   localparam int HASH_ENTRIES = 16384;
   localparam int HASH_AW      = 14;
   localparam int ENTRY_W      = 32;
   localparam int CODE_W       = 12;
   localparam int KEY_W        = 20;
   localparam int ACC_W        = 20;

   localparam logic [CODE_W-1:0] CODE_CLEAR = 12'h100;
   localparam logic [CODE_W-1:0] CODE_END   = 12'h101;
   localparam logic [12:0]       CODE_FIRST = 13'd258;
   localparam logic [12:0]       MAX_CODES  = 13'd4096;
   localparam logic [3:0]        SIZE_MIN   = 4'd9;
   localparam logic [3:0]        SIZE_MAX   = 4'd12;

   typedef struct packed {
      logic              put;
      logic              flush;
      logic              is_end;
      logic [CODE_W-1:0] code;
      logic [3:0]        size;
   } pk_cmd_type;

   typedef struct packed {
      logic put_ok;
      logic flush_ok;
   } pk_stat_type;

   // code size grows once next code passes the current range
   function automatic logic [3:0] grow(input logic [12:0] next, input logic [3:0] size);
      logic [3:0] res;
      res = size;
      if ((next > (13'd1 << size)) && (size < SIZE_MAX)) begin
         res = size + 4'd1;
      end
      return res;
   endfunction

endpackage

FILE: rtl/core/gif_lzw_encoder_top.sv
// GIF LZW encoder top level: sequencer, hash dictionary RAM and bit packer.
// Depends on gle_pkg, gle_ram and gle_packer.
`timescale 1ns / 1ps

// Usage:
//   req channel: one pixel per request. tdata[7:0] pixel, tuser = first pixel
//   of frame, tlast = last pixel of frame.
//   rsp channel: packed LZW code bytes, LSB first; tlast marks the final
//   flushed byte of a frame. One request yields 0 to 7 bytes.
//   The sequencer handles one pixel at a time and drops req_tready meanwhile.
//   From one accepted request to the next the sequencer passes S_FIRST and
//   S_MAIN. A pixel that only starts a string goes on to S_TOP; else S_CMP
//   probes the hash, steps to the next slot on a mismatch, and goes to S_TOP
//   on a hit or via S_MISS on a miss; then S_LASTA and S_DONE. A last pixel
//   adds its code in S_LASTA, the end code in S_LASTB and the flush in S_FLUSH.
//   Every code write also waits while the packer drains earlier bytes, one
//   a cycle unless rsp_tready stalls it. Probe chains in the dictionary RAM
//   and the packer set the pace. Reset (synchronous, active high) clears the
//   control state and then sweeps the 16384-entry dictionary, one entry per
//   cycle, before the first request, and again after every first-pixel
//   request and dictionary-full clear. A stalled rsp_tready holds the output
//   byte and stops draining; codes then wait while 8 or more bits are held.
module gif_lzw_encoder_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] pixel
   input  logic       req_tuser,   // [0] first_pixel
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast
);

   localparam logic [3:0] S_SWEEP = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_FIRST = 4'd2;
   localparam logic [3:0] S_MAIN  = 4'd3;
   localparam logic [3:0] S_CMP   = 4'd4;
   localparam logic [3:0] S_MISS  = 4'd5;
   localparam logic [3:0] S_TOP   = 4'd6;
   localparam logic [3:0] S_LASTA = 4'd7;
   localparam logic [3:0] S_LASTB = 4'd8;
   localparam logic [3:0] S_FLUSH = 4'd9;
   localparam logic [3:0] S_DONE  = 4'd10;

   logic [3:0]                   st_ff, st_in;
   logic [7:0]                   pix_ff, pix_in;
   logic                         first_ff, first_in;
   logic                         last_ff, last_in;
   logic [gle_pkg::HASH_AW-1:0]  pos_ff, pos_in;
   logic [gle_pkg::CODE_W-1:0]   work_ff, work_in;
   logic                         have_ff, have_in;
   logic [12:0]                  next_ff, next_in;
   logic [3:0]                   size_ff, size_in;
   logic                         clrp_ff, clrp_in;
   logic [gle_pkg::HASH_AW-1:0]  swp_ff, swp_in;

   logic                         wr_en;
   logic [gle_pkg::HASH_AW-1:0]  wr_addr;
   logic [gle_pkg::ENTRY_W-1:0]  wr_data;
   logic [gle_pkg::ENTRY_W-1:0]  rd_data;
   logic [gle_pkg::KEY_W-1:0]    key;
   logic [3:0]                   gsize;

   gle_pkg::pk_cmd_type  pk_cmd;
   gle_pkg::pk_stat_type pk_stat;

   assign key        = {work_ff, pix_ff};
   assign gsize      = gle_pkg::grow(next_ff, size_ff);
   assign req_tready = (st_ff == S_IDLE);

   always_comb begin
      st_in    = st_ff;
      pix_in   = pix_ff;
      first_in = first_ff;
      last_in  = last_ff;
      pos_in   = pos_ff;
      work_in  = work_ff;
      have_in  = have_ff;
      next_in  = next_ff;
      size_in  = size_ff;
      clrp_in  = clrp_ff;
      swp_in   = swp_ff;
      wr_en    = 1'b0;
      wr_addr  = pos_ff;
      wr_data  = {key, next_ff[gle_pkg::CODE_W-1:0]};
      pk_cmd   = '0;
      unique case (st_ff)
         S_SWEEP: begin
            wr_en   = 1'b1;
            wr_addr = swp_ff;
            wr_data = '0;
            swp_in  = swp_ff + 1'b1;
            if (&swp_ff) begin
               clrp_in = 1'b0;
               st_in   = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               pix_in   = req_tdata;
               first_in = req_tuser;
               last_in  = req_tlast;
               // hash start: key bits [19:6]
               pos_in   = {work_ff, req_tdata[7:6]};
               st_in    = S_FIRST;
            end
         end
         S_FIRST: begin
            if (!first_ff) begin
               st_in = S_MAIN;
            end else if (pk_stat.put_ok) begin
               pk_cmd.put  = 1'b1;
               pk_cmd.code = gle_pkg::CODE_CLEAR;
               pk_cmd.size = gle_pkg::SIZE_MIN;
               size_in     = gle_pkg::SIZE_MIN;
               next_in     = gle_pkg::CODE_FIRST;
               have_in     = 1'b0;
               clrp_in     = 1'b1;
               st_in       = S_MAIN;
            end
         end
         S_MAIN: begin
            if (!have_ff) begin
               work_in = {4'd0, pix_ff};
               have_in = 1'b1;
               st_in   = S_TOP;
            end else begin
               st_in = S_CMP;
            end
         end
         S_CMP: begin
            if (rd_data == '0) begin
               st_in = S_MISS;
            end else if (rd_data[gle_pkg::ENTRY_W-1:gle_pkg::CODE_W] == key) begin
               work_in = rd_data[gle_pkg::CODE_W-1:0];
               st_in   = S_TOP;
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end
         S_MISS: begin
            if (pk_stat.put_ok) begin
               pk_cmd.put  = 1'b1;
               pk_cmd.code = work_ff;
               pk_cmd.size = gsize;
               size_in     = gsize;
               wr_en       = 1'b1;
               next_in     = next_ff + 13'd1;
               work_in     = {4'd0, pix_ff};
               st_in       = S_TOP;
            end
         end
         S_TOP: begin
            if (next_ff < gle_pkg::MAX_CODES) begin
               st_in = S_LASTA;
            end else if (pk_stat.put_ok) begin
               pk_cmd.put  = 1'b1;
               pk_cmd.code = gle_pkg::CODE_CLEAR;
               pk_cmd.size = size_ff;
               size_in     = gle_pkg::SIZE_MIN;
               next_in     = gle_pkg::CODE_FIRST;
               clrp_in     = 1'b1;
               st_in       = S_LASTA;
            end
         end
         S_LASTA: begin
            if (!last_ff) begin
               st_in = S_DONE;
            end else if (pk_stat.put_ok) begin
               pk_cmd.put  = 1'b1;
               pk_cmd.code = work_ff;
               pk_cmd.size = gsize;
               size_in     = gsize;
               next_in     = next_ff + 13'd1;
               st_in       = S_LASTB;
            end
         end
         S_LASTB: begin
            if (pk_stat.put_ok) begin
               pk_cmd.put    = 1'b1;
               pk_cmd.is_end = 1'b1;
               pk_cmd.code   = gle_pkg::CODE_END;
               pk_cmd.size   = gsize;
               size_in       = gsize;
               next_in       = next_ff + 13'd1;
               st_in         = S_FLUSH;
            end
         end
         S_FLUSH: begin
            pk_cmd.flush = 1'b1;
            if (pk_stat.flush_ok) begin
               have_in = 1'b0;
               st_in   = S_DONE;
            end
         end
         S_DONE: begin
            if (clrp_ff) begin
               swp_in = '0;
               st_in  = S_SWEEP;
            end else begin
               st_in = S_IDLE;
            end
         end
         default: begin
            st_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= S_SWEEP;
         swp_ff  <= '0;
         clrp_ff <= 1'b0;
         work_ff <= '0;
         have_ff <= 1'b0;
         next_ff <= gle_pkg::CODE_FIRST;
         size_ff <= gle_pkg::SIZE_MIN;
      end else begin
         st_ff   <= st_in;
         swp_ff  <= swp_in;
         clrp_ff <= clrp_in;
         work_ff <= work_in;
         have_ff <= have_in;
         next_ff <= next_in;
         size_ff <= size_in;
      end
      pix_ff   <= pix_in;
      first_ff <= first_in;
      last_ff  <= last_in;
      pos_ff   <= pos_in;
   end

   gle_ram #(
      .WIDTH(gle_pkg::ENTRY_W),
      .DEPTH(gle_pkg::HASH_ENTRIES)
   ) u_dict (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (pos_in),
      .rd_data (rd_data)
   );

   gle_packer u_packer (
      .clock      (clock),
      .reset      (reset),
      .cmd        (pk_cmd),
      .stat       (pk_stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: rtl/core/gle_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module gle_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/gle_packer.sv
// Bit packer: accumulates variable-size codes LSB first and emits bytes.
// Depends on gle_pkg.
`timescale 1ns / 1ps

module gle_packer (
   input  logic                clock,
   input  logic                reset,
   input  gle_pkg::pk_cmd_type cmd,
   output gle_pkg::pk_stat_type stat,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,
   output logic                rsp_tlast
);

   logic [gle_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic [4:0]                cnt_ff, cnt_in;
   logic                      end_ff, end_in;
   logic [7:0]                ob_ff, ob_in;
   logic                      ol_ff, ol_in;
   logic                      ov_ff, ov_in;
   logic                      out_free;
   logic                      busy;
   logic [11:0]               mask;

   always_comb begin
      out_free = !ov_ff || rsp_tready;
      busy     = (cnt_ff >= 5'd8);
      mask     = 12'((13'd1 << cmd.size) - 13'd1);
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      end_in   = end_ff;
      ob_in    = ob_ff;
      ol_in    = ol_ff;
      ov_in    = ov_ff;
      if (ov_ff && rsp_tready) begin
         ov_in = 1'b0;
      end
      if (busy) begin
         if (out_free) begin
            ob_in  = acc_ff[7:0];
            ol_in  = end_ff && (cnt_ff == 5'd8);
            ov_in  = 1'b1;
            acc_in = acc_ff >> 8;
            cnt_in = cnt_ff - 5'd8;
         end
      end else if (cmd.put) begin
         acc_in = acc_ff | (gle_pkg::ACC_W'(cmd.code & mask) << cnt_ff);
         cnt_in = cnt_ff + 5'(cmd.size);
         end_in = cmd.is_end;
      end else if (cmd.flush && ((cnt_ff == 5'd0) || out_free)) begin
         if (cnt_ff != 5'd0) begin
            ob_in = acc_ff[7:0];
            ol_in = 1'b1;
            ov_in = 1'b1;
         end
         acc_in = '0;
         cnt_in = '0;
      end
      stat.put_ok   = !busy;
      stat.flush_ok = !busy && ((cnt_ff == 5'd0) || out_free);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         cnt_ff <= '0;
         end_ff <= 1'b0;
         ov_ff  <= 1'b0;
      end else begin
         acc_ff <= acc_in;
         cnt_ff <= cnt_in;
         end_ff <= end_in;
         ov_ff  <= ov_in;
      end
      ob_ff <= ob_in;
      ol_ff <= ol_in;
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = ob_ff;
   assign rsp_tlast  = ol_ff;

endmodule

FILE: rtl/core/gle_checker.sv
// Port-level checker for the GIF LZW encoder, bound to the top level.
// Depends on gif_lzw_encoder_top_macros.svh and gif_lzw_encoder_top.
`timescale 1ns / 1ps
`include "gif_lzw_encoder_top_macros.svh"

module gle_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   // a stalled byte holds
   `GLE_ASSERT_RST(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "rsp byte changed under stall")
   // one request at a time
   `GLE_ASSERT_RST(a_req_seq, clock, reset, req_tvalid && req_tready |=> !req_tready, "request taken while busy")
   // dictionary sweep follows reset
   `GLE_ASSERT_ALL(a_rst_sweep, clock, reset |=> !req_tready, "ready right after reset")
   `GLE_ASSERT_ALL(a_rst_out, clock, reset |=> !rsp_tvalid, "output valid right after reset")

endmodule

bind gif_lzw_encoder_top gle_checker u_gle_checker (.*);
